FILE: sv/rda_pkg.sv
// Shared widths, constants, command/status types and helpers of the rotary detent accumulator.
package rda_pkg;

  localparam int SENSOR_COUNT = 4;
  localparam int LAYER_COUNT  = 8;
  localparam int SLOTS        = SENSOR_COUNT * LAYER_COUNT;
  localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // field widths
  localparam int SENSOR_W = 2;
  localparam int LAYER_W  = 3;
  localparam int DEG_W    = 16;
  localparam int MICRO_W  = 21;
  localparam int TRIG_W   = 21;
  localparam int TPR_W    = 9;

  // bus widths
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = SENSOR_W + LAYER_W;
  localparam int OUT_TDATA_W = 24;

  // stored remainder entry: {degrees, micro}
  localparam int REM_DEG_W   = 10;
  localparam int REM_MICRO_W = 21;
  localparam int ENTRY_W     = REM_DEG_W + REM_MICRO_W;

  // working sums
  localparam int SUM_DEG_W   = 18;
  localparam int SUM_MICRO_W = 22;

  // shared divider
  localparam int DVD_W      = 17;
  localparam int DVS_W      = 9;
  localparam int CNT_W      = 5;
  localparam int STEP_ITERS = TPR_W;
  localparam int RD_ITERS   = DVD_W;

  localparam int MICRO_PER_DEG = 1000000;
  localparam int FULL_TURN     = 360;
  localparam int TRIG_LIMIT    = 999999;
  localparam int TPR_RESET     = 20;
  localparam int STEP_RESET    = FULL_TURN / TPR_RESET;

  typedef struct packed {
    logic capture;
    logic cfg_load;
    logic step_load;
    logic read;
    logic add;
    logic carry;
    logic write;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic direct;    // incoming beat needs no remainder update
    logic div_done;
    logic out_free;
  } dp_sts_t;

  function automatic logic signed [TRIG_W-1:0] sat_trig(input logic signed [SUM_MICRO_W-1:0] v);
    logic signed [TRIG_W-1:0] r;
    if (v > TRIG_LIMIT) begin
      r = TRIG_W'(TRIG_LIMIT);
    end else if (v < -TRIG_LIMIT) begin
      r = TRIG_W'(-TRIG_LIMIT);
    end else begin
      r = v[TRIG_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/rotary_detent_accumulator_unit.sv
// Rotary detent accumulator top level: stream ports, controller and datapath.
// Flow: a rotation beat passes the read, add, carry, divide and write states before its result
//   is loaded; a legacy tick beat or one for an unknown sensor/layer is loaded directly.
// Beats: one in flight at a time, divided on the 17-step shared radix-2 divider;
//   a new beat is taken only once the last result is in the output register.
// Config write: the step size is recomputed on the same divider, both channels held off.
// Reset: async active low; remainders read as zero, detents per turn back to 20.
module rotary_detent_accumulator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beat
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [15:0] degrees, [36:16] micro_degrees, rest zero
  input  logic [4:0]  s_axis_tuser_i,   // [1:0] sensor_id, [4:2] layer
  // result beat
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [20:0] trigger_count, rest zero
  // detents-per-turn register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i
);

  rda_pkg::dp_cmd_t cmd;
  rda_pkg::dp_sts_t sts;

  // controller: one beat in flight, ready only when idle
  rda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: remainder RAM, carry, divider and the output register that
  // lets a new beat come in while a result still waits downstream
  rda_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .cfg_data_i (cfg_data_i),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o)
  );

  // a config write and an input beat never land together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tvalid_i && s_axis_tready_o && cfg_valid_i && cfg_ready_o))
    else $error("input beat and config write accepted together");

  // in the cycle after an input beat neither channel is ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (!s_axis_tready_o && !cfg_ready_o))
    else $error("ready stayed high after input beat");

  // a config write holds off both channels while the step size is rebuilt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> (!s_axis_tready_o && !cfg_ready_o))
    else $error("ready high during step computation");

  // in-range legacy tick passes straight through when the output is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o &&
     (s_axis_tdata_i[15:0] == 16'd0) &&
     ($signed(s_axis_tdata_i[36:16]) <= 999999) &&
     ($signed(s_axis_tdata_i[36:16]) >= -999999))
    |-> ##2 (m_axis_tvalid_o && (m_axis_tdata_o[20:0] == $past(s_axis_tdata_i[36:16], 2))))
    else $error("legacy tick result wrong or late");

endmodule

FILE: sv/rda_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/rda_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, unsigned operands.
module rda_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rda_pkg::DVD_W-1:0]   dividend_i,
  input  logic [rda_pkg::DVS_W-1:0]   divisor_i,
  input  logic [rda_pkg::CNT_W-1:0]   iters_i,
  output logic                        done_o,
  output logic [rda_pkg::DVD_W-1:0]   quotient_o,
  output logic [rda_pkg::DVS_W-1:0]   remainder_o
);

  logic [rda_pkg::DVS_W:0]   rem_q, rem_d;
  logic [rda_pkg::DVD_W-1:0] quo_q, quo_d;
  logic [rda_pkg::DVD_W-1:0] dvd_q, dvd_d;
  logic [rda_pkg::DVS_W-1:0] dvs_q, dvs_d;
  logic [rda_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      done_q, done_d;
  logic [rda_pkg::DVS_W:0]   trial;

  // remainder stays below the divisor, so its top bit is always clear
  assign trial = {rem_q[rda_pkg::DVS_W-1:0], dvd_q[rda_pkg::DVD_W-1]};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = '0;
      dvd_d = dividend_i;
      dvs_d = divisor_i;
      cnt_d = iters_i;
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[rda_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[rda_pkg::DVD_W-2:0], 1'b0};
      end
      dvd_d  = {dvd_q[rda_pkg::DVD_W-2:0], 1'b0};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == rda_pkg::CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q[rda_pkg::DVS_W-1:0];

endmodule

FILE: sv/rda_dp.sv
// Datapath: input capture, remainder store, carry, shared divider and output register.
module rda_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rda_pkg::dp_cmd_t                 cmd_i,
  output rda_pkg::dp_sts_t                 sts_o,
  input  logic [rda_pkg::IN_TDATA_W-1:0]   s_tdata_i,
  input  logic [rda_pkg::IN_TUSER_W-1:0]   s_tuser_i,
  input  logic [rda_pkg::TPR_W-1:0]        cfg_data_i,
  input  logic                             m_tready_i,
  output logic                             m_tvalid_o,
  output logic [rda_pkg::OUT_TDATA_W-1:0]  m_tdata_o
);

  localparam logic signed [rda_pkg::SUM_MICRO_W-1:0] ONE_MEG =
    rda_pkg::SUM_MICRO_W'(rda_pkg::MICRO_PER_DEG);
  localparam logic signed [rda_pkg::SUM_MICRO_W-1:0] TWO_MEG =
    rda_pkg::SUM_MICRO_W'(2 * rda_pkg::MICRO_PER_DEG);
  localparam logic [rda_pkg::DVD_W-1:0] STEP_DVD =
    rda_pkg::DVD_W'(rda_pkg::FULL_TURN) << (rda_pkg::DVD_W - rda_pkg::TPR_W);

  // input fields
  logic [rda_pkg::SENSOR_W-1:0]       in_sensor;
  logic [rda_pkg::LAYER_W-1:0]        in_layer;
  logic signed [rda_pkg::DEG_W-1:0]   in_deg;
  logic signed [rda_pkg::MICRO_W-1:0] in_micro;
  logic                               in_slot_ok;
  logic [rda_pkg::SLOT_W-1:0]         in_slot;

  assign in_sensor = s_tuser_i[rda_pkg::SENSOR_W-1:0];
  assign in_layer  = s_tuser_i[rda_pkg::IN_TUSER_W-1:rda_pkg::SENSOR_W];
  assign in_deg    = s_tdata_i[rda_pkg::DEG_W-1:0];
  assign in_micro  = s_tdata_i[rda_pkg::DEG_W+rda_pkg::MICRO_W-1:rda_pkg::DEG_W];

  assign in_slot_ok = (32'(in_sensor) < rda_pkg::SENSOR_COUNT) &&
                      (32'(in_layer) < rda_pkg::LAYER_COUNT);
  assign in_slot    = rda_pkg::SLOT_W'(32'(in_sensor) * rda_pkg::LAYER_COUNT + 32'(in_layer));

  // registers
  logic signed [rda_pkg::DEG_W-1:0]       deg_q;
  logic signed [rda_pkg::MICRO_W-1:0]     micro_q;
  logic [rda_pkg::SLOT_W-1:0]             slot_q;
  logic signed [rda_pkg::TRIG_W-1:0]      res_q;
  logic [rda_pkg::DVS_W-1:0]              step_q;
  logic [rda_pkg::SLOTS-1:0]              vld_q;
  logic                                   vld_rd_q;
  logic signed [rda_pkg::SUM_DEG_W-1:0]   rd_sum_q;
  logic signed [rda_pkg::SUM_MICRO_W-1:0] rm_sum_q;
  logic signed [rda_pkg::REM_MICRO_W-1:0] rm_fix_q;
  logic                                   neg_q;
  logic                                   out_valid_q;
  logic signed [rda_pkg::TRIG_W-1:0]      out_data_q;

  // remainder store
  logic [rda_pkg::ENTRY_W-1:0]            rdata;
  logic [rda_pkg::ENTRY_W-1:0]            wdata;
  logic signed [rda_pkg::REM_DEG_W-1:0]   old_deg;
  logic signed [rda_pkg::REM_MICRO_W-1:0] old_micro;

  rda_ram #(
    .WIDTH (rda_pkg::ENTRY_W),
    .DEPTH (rda_pkg::SLOTS)
  ) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .waddr_i (slot_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.read),
    .raddr_i (slot_q),
    .rdata_o (rdata)
  );

  // never-written entries read as zero
  assign old_deg   = vld_rd_q ? rdata[rda_pkg::ENTRY_W-1:rda_pkg::REM_MICRO_W] : '0;
  assign old_micro = vld_rd_q ? rdata[rda_pkg::REM_MICRO_W-1:0] : '0;

  // micro carry: the sum stays below three million in magnitude
  logic signed [rda_pkg::SUM_DEG_W-1:0]   carry;
  logic signed [rda_pkg::SUM_MICRO_W-1:0] rm_fix;
  logic signed [rda_pkg::SUM_DEG_W-1:0]   rd_fix;
  logic [rda_pkg::SUM_DEG_W-1:0]          rd_mag;

  always_comb begin
    if (rm_sum_q >= TWO_MEG) begin
      carry  = rda_pkg::SUM_DEG_W'(2);
      rm_fix = rm_sum_q - TWO_MEG;
    end else if (rm_sum_q >= ONE_MEG) begin
      carry  = rda_pkg::SUM_DEG_W'(1);
      rm_fix = rm_sum_q - ONE_MEG;
    end else if (rm_sum_q <= -TWO_MEG) begin
      carry  = rda_pkg::SUM_DEG_W'(-2);
      rm_fix = rm_sum_q + TWO_MEG;
    end else if (rm_sum_q <= -ONE_MEG) begin
      carry  = rda_pkg::SUM_DEG_W'(-1);
      rm_fix = rm_sum_q + ONE_MEG;
    end else begin
      carry  = '0;
      rm_fix = rm_sum_q;
    end
    rd_fix = rd_sum_q + carry;
    rd_mag = rd_fix[rda_pkg::SUM_DEG_W-1] ? -rd_fix : rd_fix;
  end

  // step size from the configured detent count, clamped to 1..360
  logic [rda_pkg::TPR_W-1:0] tpr_clamped;

  always_comb begin
    if (cfg_data_i == '0) begin
      tpr_clamped = rda_pkg::TPR_W'(1);
    end else if (cfg_data_i > rda_pkg::TPR_W'(rda_pkg::FULL_TURN)) begin
      tpr_clamped = rda_pkg::TPR_W'(rda_pkg::FULL_TURN);
    end else begin
      tpr_clamped = cfg_data_i;
    end
  end

  // shared divider
  logic                      div_start;
  logic [rda_pkg::DVD_W-1:0] div_dvd;
  logic [rda_pkg::DVS_W-1:0] div_dvs;
  logic [rda_pkg::CNT_W-1:0] div_iters;
  logic                      div_done;
  logic [rda_pkg::DVD_W-1:0] div_quo;
  logic [rda_pkg::DVS_W-1:0] div_rem;

  assign div_start = cmd_i.cfg_load | cmd_i.carry;
  assign div_dvd   = cmd_i.carry ? rd_mag[rda_pkg::DVD_W-1:0] : STEP_DVD;
  assign div_dvs   = cmd_i.carry ? step_q : tpr_clamped;
  assign div_iters = cmd_i.carry ? rda_pkg::CNT_W'(rda_pkg::RD_ITERS)
                                 : rda_pkg::CNT_W'(rda_pkg::STEP_ITERS);

  rda_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvs),
    .iters_i     (div_iters),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // signed quotient and remainder, truncated towards zero
  logic signed [rda_pkg::SUM_MICRO_W-1:0] quo_ext;
  logic signed [rda_pkg::SUM_MICRO_W-1:0] trig_full;
  logic signed [rda_pkg::REM_DEG_W-1:0]   rem_ext;
  logic signed [rda_pkg::REM_DEG_W-1:0]   rem_deg;
  logic signed [rda_pkg::SUM_MICRO_W-1:0] legacy_ext;

  assign quo_ext    = rda_pkg::SUM_MICRO_W'(div_quo);
  assign trig_full  = neg_q ? -quo_ext : quo_ext;
  assign rem_ext    = rda_pkg::REM_DEG_W'(div_rem);
  assign rem_deg    = neg_q ? -rem_ext : rem_ext;
  assign wdata      = {rem_deg, rm_fix_q};
  assign legacy_ext = rda_pkg::SUM_MICRO_W'(in_micro);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= rda_pkg::DVS_W'(rda_pkg::STEP_RESET);
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.step_load) begin
        step_q <= div_quo[rda_pkg::DVS_W-1:0];
      end
      if (cmd_i.write) begin
        vld_q[slot_q] <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      deg_q   <= in_deg;
      micro_q <= in_micro;
      slot_q  <= in_slot;
      // legacy ticks pass straight through; an unknown slot gives zero
      res_q   <= (in_deg == '0) ? rda_pkg::sat_trig(legacy_ext) : '0;
    end
    if (cmd_i.read) begin
      vld_rd_q <= vld_q[slot_q];
    end
    if (cmd_i.add) begin
      rd_sum_q <= rda_pkg::SUM_DEG_W'(old_deg) + rda_pkg::SUM_DEG_W'(deg_q);
      rm_sum_q <= rda_pkg::SUM_MICRO_W'(old_micro) + rda_pkg::SUM_MICRO_W'(micro_q);
    end
    if (cmd_i.carry) begin
      neg_q    <= rd_fix[rda_pkg::SUM_DEG_W-1];
      rm_fix_q <= rm_fix[rda_pkg::REM_MICRO_W-1:0];
    end
    if (cmd_i.write) begin
      res_q <= rda_pkg::sat_trig(trig_full);
    end
    if (cmd_i.out_load) begin
      out_data_q <= res_q;
    end
  end

  assign sts_o.direct   = (in_deg == '0) || !in_slot_ok;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(rda_pkg::OUT_TDATA_W - rda_pkg::TRIG_W){1'b0}}, out_data_q};

endmodule

FILE: sv/rda_ctrl.sv
// Controller: sequences config step computation and the per-beat accumulate and divide.
module rda_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  rda_pkg::dp_sts_t sts_i,
  output rda_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_STEP  = 8'b0000_0010,
    S_READ  = 8'b0000_0100,
    S_ADD   = 8'b0000_1000,
    S_CARRY = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_WRITE = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    s_tready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cfg_ready_o = 1'b1;
        s_tready_o  = !cfg_valid_i;
        if (cfg_valid_i) begin
          cmd_o.cfg_load = 1'b1;
          state_d        = S_STEP;
        end else if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = sts_i.direct ? S_DONE : S_READ;
        end
      end
      S_STEP: begin
        if (sts_i.div_done) begin
          cmd_o.step_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_CARRY;
      end
      S_CARRY: begin
        cmd_o.carry = 1'b1;
        state_d     = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
